// ===== rtl/asts_pkg.sv =====
// Package for the aging score thread scheduler: slot table sizes, field widths,
// operation codes and the result type of the aging unit.
// No dependencies; used by asts_age_unit and aging_score_thread_scheduler.
package asts_pkg;

    localparam int SLOTS      = 16;
    localparam int FIRST_SLOT = 2;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int PRIO_W  = 16;
    localparam int SCORE_W = 32;
    localparam int ID_W    = 4;
    localparam int OP_W    = 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 2'd0,
        OP_DESTROY  = 2'd1,
        OP_SCHEDULE = 2'd2
    } t_op;

    typedef struct packed {
        logic [SCORE_W-1:0] score;   // aged score, saturated
        logic               better;  // old score beats the best so far
    } t_age_res;

endpackage

// ===== rtl/asts_age_unit.sv =====
// Aging step for one slot: saturating add of priority to score and the
// strict compare against the best score of the current scan.
// Depends on asts_pkg.
module asts_age_unit (
    input  logic [asts_pkg::SCORE_W-1:0] i_score,
    input  logic [asts_pkg::PRIO_W-1:0]  i_prio,
    input  logic [asts_pkg::SCORE_W-1:0] i_best,
    output asts_pkg::t_age_res           o_res
);

    logic [asts_pkg::SCORE_W:0] sum;

    always_comb begin
        sum = {1'b0, i_score} + (asts_pkg::SCORE_W + 1)'(i_prio);
        // clamp at the top of the range on carry out
        o_res.score  = sum[asts_pkg::SCORE_W] ? asts_pkg::SCORE_MAX
                                              : sum[asts_pkg::SCORE_W-1:0];
        o_res.better = (i_score > i_best);
    end

endmodule

// ===== rtl/aging_score_thread_scheduler.sv =====
// Aging score thread scheduler: slot table with create, destroy and schedule.
// Depends on asts_pkg and asts_age_unit.
//
// Input channel s_axis: one transaction per command. tuser carries the
// operation (create, destroy, schedule), tdata the priority, privileged mark
// and slot id. Output channel m_axis: exactly one result transaction per
// command; tuser is the fail flag, tdata the chosen id and privileged mark.
// Priorities and scores live in one memory of SLOTS entries with a registered
// read; occupancy and privileged marks are flip-flops.
// Create and destroy go through the command state, then the done state loads the result.
// Schedule walks the memory one slot per cycle, from FIRST_SLOT upward,
// reading, aging and writing back each occupied slot, then clears the winner's
// score in the clear state; when nothing wins, the clear state is skipped.
// One command is processed at a time; s_axis_tready is high while idle,
// including while an earlier result still waits on m_axis.
// Reset (synchronous, active low) frees every slot and drops any pending
// result; no clearing pass is needed, since create writes the score first.
// A stalled receiver holds the result register; a finished command then
// waits before loading it, and no new command is taken meanwhile.
module aging_score_thread_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // prio[15:0], privileged[16], slot_id[20:17], zero
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // chosen_id[3:0], chosen_privileged[4], zero
    output logic        m_axis_tuser   // status[0]
);

    localparam int IDX_W   = asts_pkg::IDX_W;
    localparam int CNT_W   = asts_pkg::CNT_W;
    localparam int PRIO_W  = asts_pkg::PRIO_W;
    localparam int SCORE_W = asts_pkg::SCORE_W;
    localparam int ID_W    = asts_pkg::ID_W;
    localparam int SLOTS   = asts_pkg::SLOTS;
    localparam int FIRST   = asts_pkg::FIRST_SLOT;
    localparam int MEM_W   = PRIO_W + SCORE_W;
    localparam logic [SLOTS-1:0] LOW_MASK = SLOTS'((1 << FIRST) - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CMD   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_CLEAR = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    asts_pkg::t_op        r_op, n_op;
    logic [PRIO_W-1:0]    r_prio, n_prio;
    logic                 r_priv_in, n_priv_in;
    logic [ID_W-1:0]      r_sid, n_sid;
    logic [SLOTS-1:0]     r_used, n_used;
    logic [SLOTS-1:0]     r_priv, n_priv;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic [SCORE_W-1:0]   r_best_score, n_best_score;
    logic [IDX_W-1:0]     r_best_id, n_best_id;
    logic [PRIO_W-1:0]    r_best_prio, n_best_prio;
    logic                 r_found, n_found;
    logic                 r_res_status, n_res_status;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    logic                 r_res_priv, n_res_priv;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_status, n_out_status;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic                 r_out_priv, n_out_priv;

    logic [MEM_W-1:0]     mem [SLOTS];
    logic [MEM_W-1:0]     r_mem_q;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    logic [PRIO_W-1:0]    q_prio;
    logic [SCORE_W-1:0]   q_score;
    asts_pkg::t_age_res   age;

    logic                 free_hit;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     sid_idx;
    logic                 sid_ok;

    assign q_prio  = r_mem_q[MEM_W-1:SCORE_W];
    assign q_score = r_mem_q[SCORE_W-1:0];

    asts_age_unit u_age (
        .i_score (q_score),
        .i_prio  (q_prio),
        .i_best  (r_best_score),
        .o_res   (age)
    );

    assign mem_raddr = r_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    // lowest free slot at or above FIRST_SLOT
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= FIRST; i--) begin
            if (!r_used[i]) begin
                free_hit = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign sid_idx = IDX_W'(r_sid);
    assign sid_ok  = (32'(r_sid) < 32'(SLOTS)) && r_used[sid_idx];

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_prio       = r_prio;
        n_priv_in    = r_priv_in;
        n_sid        = r_sid;
        n_used       = r_used;
        n_priv       = r_priv;
        n_idx        = r_idx;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_best_score = r_best_score;
        n_best_id    = r_best_id;
        n_best_prio  = r_best_prio;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_priv   = r_res_priv;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_priv   = r_out_priv;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op      = asts_pkg::t_op'(s_axis_tuser);
                    n_prio    = s_axis_tdata[15:0];
                    n_priv_in = s_axis_tdata[16];
                    n_sid     = s_axis_tdata[20:17];
                    n_state   = ST_CMD;
                end
            end
            ST_CMD: begin
                n_res_status = 1'b1;
                n_res_id     = '0;
                n_res_priv   = 1'b0;
                n_state      = ST_DONE;
                unique case (r_op)
                    asts_pkg::OP_CREATE: begin
                        if (free_hit) begin
                            n_used[free_idx] = 1'b1;
                            n_priv[free_idx] = r_priv_in;
                            mem_we           = 1'b1;
                            mem_waddr        = free_idx;
                            mem_wdata        = {r_prio, {SCORE_W{1'b0}}};
                            n_res_status     = 1'b0;
                            n_res_id         = ID_W'(free_idx);
                            n_res_priv       = r_priv_in;
                        end
                    end
                    asts_pkg::OP_DESTROY: begin
                        if (sid_ok) begin
                            n_used[sid_idx] = 1'b0;
                            n_priv[sid_idx] = 1'b0;
                            n_res_status    = 1'b0;
                        end
                    end
                    asts_pkg::OP_SCHEDULE: begin
                        n_idx        = CNT_W'(FIRST);
                        n_rd_vld     = 1'b0;
                        n_best_score = '0;
                        n_found      = 1'b0;
                        n_state      = ST_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                // issue stage: read one slot per cycle
                if (32'(r_idx) < 32'(SLOTS)) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
                // update stage: age the slot read last cycle and write it back
                if (r_rd_vld && r_used[r_rd_idx]) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx;
                    mem_wdata = {q_prio, age.score};
                    if (age.better) begin
                        n_best_score = q_score;
                        n_best_id    = r_rd_idx;
                        n_best_prio  = q_prio;
                        n_found      = 1'b1;
                    end
                end
                if ((32'(r_idx) == 32'(SLOTS)) && !r_rd_vld) begin
                    if (r_found) begin
                        n_state = ST_CLEAR;
                    end else begin
                        n_res_status = 1'b1;
                        n_res_id     = '0;
                        n_res_priv   = 1'b0;
                        n_state      = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = r_best_id;
                mem_wdata    = {r_best_prio, {SCORE_W{1'b0}}};
                n_res_status = 1'b0;
                n_res_id     = ID_W'(r_best_id);
                n_res_priv   = r_priv[r_best_id];
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_priv   = r_res_priv;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_priv      <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_priv      <= n_priv;
            r_rd_vld    <= n_rd_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_prio       <= n_prio;
        r_priv_in    <= n_priv_in;
        r_sid        <= n_sid;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_best_score <= n_best_score;
        r_best_id    <= n_best_id;
        r_best_prio  <= n_best_prio;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_priv   <= n_res_priv;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_priv   <= n_out_priv;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'b000, r_out_priv, r_out_id};

`ifndef NO_ASSERTIONS
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_rd_vld)
        else $error("scan read still in flight while idle");

    a_low_slots_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used & LOW_MASK) == '0)
        else $error("slot below the first usable slot is occupied");

    a_clear_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (r_found && r_used[r_best_id]))
        else $error("clearing a winner that is not an occupied slot");

    a_scan_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SCAN) |-> $past(r_state == ST_CMD && r_op == asts_pkg::OP_SCHEDULE))
        else $error("scan started without a schedule command");
`endif

endmodule
